[sv/ers_pkg.sv]
// ers_pkg: shared types, constants and floor scan functions for the elevator
// request scheduler. No dependencies; every other file imports it.

package ers_pkg;

  // building size and field widths
  localparam int FLOORS  = 16;
  localparam int FLR_W   = 4;
  localparam int OP_W    = 3;
  localparam int CMD_W   = 3;
  localparam int QDEPTH  = 3;
  localparam int QCNT_W  = 2;

  typedef logic [FLOORS-1:0] req_vec_t;
  typedef logic [FLR_W-1:0]  floor_t;
  typedef logic [QCNT_W-1:0] qcnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADVANCE  = 3'd0,
    OP_POSITION = 3'd1,
    OP_CABIN    = 3'd2,
    OP_HALL     = 3'd3,
    OP_DOOR     = 3'd4
  } op_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESET     = 3'd0,
    CMD_CLOSE     = 3'd1,
    CMD_OPEN      = 3'd2,
    CMD_GO_UP     = 3'd3,
    CMD_GO_DOWN   = 3'd4,
    CMD_STOP      = 3'd5,
    CMD_LIGHT_ON  = 3'd6,
    CMD_LIGHT_OFF = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_INITIAL = 3'd0,
    MODE_STOPPED = 3'd1,
    MODE_UP      = 3'd2,
    MODE_DOWN    = 3'd3,
    MODE_WAITING = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // hall call direction codes
  localparam logic CALL_UP = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PICK_MID,
    ST_DEPART,
    ST_PICK,
    ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic found;
    floor_t idx;
  } scan_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic pick;
    logic depart;
    logic emit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic  is_adv;
    mode_t mode;
    logic  cnt_zero;
    logic  out_free;
    logic  emit_last;
  } dp_sts_t;

  function automatic logic floor_ok(input floor_t f);
    return (int'(f) < FLOORS);
  endfunction

  // encode a one-hot floor vector to its index
  function automatic floor_t onehot_idx(input req_vec_t oh);
    floor_t r;
    r = '0;
    for (int i = 0; i < FLOORS; i++) begin
      if (oh[i]) r = r | FLR_W'(i);
    end
    return r;
  endfunction

  // lowest set request at or above a floor
  function automatic scan_t scan_up(input req_vec_t mask, input floor_t from);
    req_vec_t m;
    req_vec_t oh;
    scan_t    r;
    for (int i = 0; i < FLOORS; i++) begin
      m[i] = mask[i] & (i >= int'(from));
    end
    oh      = m & (~m + req_vec_t'(1));
    r.found = |m;
    r.idx   = onehot_idx(oh);
    return r;
  endfunction

  // highest set request at or below a floor
  function automatic scan_t scan_down(input req_vec_t mask, input floor_t from);
    req_vec_t m;
    req_vec_t rev;
    req_vec_t oh;
    scan_t    r;
    for (int i = 0; i < FLOORS; i++) begin
      m[i] = mask[i] & (i <= int'(from));
    end
    for (int i = 0; i < FLOORS; i++) begin
      rev[i] = m[FLOORS-1-i];
    end
    oh      = rev & (~rev + req_vec_t'(1));
    r.found = |m;
    r.idx   = FLR_W'(FLOORS - 1 - int'(onehot_idx(oh)));
    return r;
  endfunction

endpackage

[sv/ers_in_if.sv]
// ers_in_if: event item channel (valid/ready plus event fields)
// depends on ers_pkg for field widths

interface ers_in_if import ers_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [FLR_W-1:0] floor;
  logic             call_direction;
  logic             door_is_open;

  modport source (output valid, operation, floor, call_direction, door_is_open,
                  input ready);
  modport sink (input valid, operation, floor, call_direction, door_is_open,
                output ready);
endinterface

[sv/ers_out_if.sv]
// ers_out_if: command item channel (valid/ready plus command fields)
// depends on ers_pkg for field widths

interface ers_out_if import ers_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [FLR_W-1:0] command_floor;
  logic             last;

  modport source (output valid, command, command_floor, last, input ready);
  modport sink (input valid, command, command_floor, last, output ready);
endinterface

[sv/elevator_request_scheduler.sv]
// Single-car elevator request scheduler. Each event item (advance step,
// position report, cabin call, hall call, door report) is taken and
// worked by a sequencer that updates the request bits and position,
// picks the next target floor with a priority scan, and for a departure
// issues close door and go up/down. A report item is updated and its
// commands sent; an advance is updated, then runs target pick, departure
// and target pick from a waiting stop, departure and target pick from a
// stop, or target pick alone otherwise, then sends its commands, one per
// cycle while the output register is free. The last command of an item
// is held in the output register, so the next item is taken while it
// waits. Depends on ers_pkg, ers_in_if, ers_out_if, ers_ctrl and ers_datapath.

module elevator_request_scheduler import ers_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  ers_in_if.sink   in_chan,
  ers_out_if.source out_chan
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencer
  ers_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // state and command output
  ers_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_chan.operation),
    .in_floor          (in_chan.floor),
    .in_call_direction (in_chan.call_direction),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_command       (out_chan.command),
    .out_command_floor (out_chan.command_floor),
    .out_last          (out_chan.last)
  );

  // a command is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("command loaded over a waiting item");

  // an accepted item is worked in the next cycle
  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> cmd.exec)
    else $error("accepted item not worked");

  // the sequencer issues one step at a time
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.exec, cmd.pick, cmd.depart, cmd.emit}))
    else $error("more than one datapath step at once");

endmodule

[sv/ers_datapath.sv]
// ers_datapath: request bits, car position, target, command queue and the
// output register of the scheduler; depends on ers_pkg

module ers_datapath import ers_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_cmd_t         cmd,
  output dp_sts_t          sts,
  input  logic [OP_W-1:0]  in_operation,
  input  logic [FLR_W-1:0] in_floor,
  input  logic             in_call_direction,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [CMD_W-1:0] out_command,
  output logic [FLR_W-1:0] out_command_floor,
  output logic             out_last
);

  // latched event item
  op_t    op_r;
  floor_t fl_r;
  logic   cdir_r;

  // scheduler state
  mode_t    mode_r, mode_nxt;
  floor_t   cur_r, cur_nxt;
  logic     tv_r, tv_nxt;
  floor_t   tf_r, tf_nxt;
  dir_t     dir_r, dir_nxt;
  req_vec_t up_r, up_nxt;
  req_vec_t dn_r, dn_nxt;

  // command queue
  cmd_t   q_cmd_r [QDEPTH];
  floor_t q_fl_r  [QDEPTH];
  qcnt_t  cnt_r, cnt_nxt;
  qcnt_t  rd_r, rd_nxt;

  // output register
  logic   out_valid_r, out_valid_nxt;
  cmd_t   out_cmd_r, out_cmd_nxt;
  floor_t out_fl_r, out_fl_nxt;
  logic   out_last_r, out_last_nxt;

  // pushes of this cycle
  logic [1:0] push_n;
  cmd_t       p0_cmd, p1_cmd;
  floor_t     p0_fl;

  // target choice
  logic   ch_tv;
  floor_t ch_tf;
  dir_t   ch_dir;
  scan_t  s_up_cur, s_dn_cur, s_sel_up, s_sel_dn, s_lo, s_hi;
  req_vec_t sel;
  logic signed [FLR_W+1:0] d_hi, d_lo;

  // event item latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= op_t'(in_operation);
      fl_r   <= in_floor;
      cdir_r <= in_call_direction;
    end
  end

  // next target for the current mode
  always_comb begin
    sel      = (dir_r == DIR_UP) ? up_r : dn_r;
    s_up_cur = scan_up(up_r, cur_r);
    s_dn_cur = scan_down(dn_r, cur_r);
    s_sel_up = scan_up(sel, cur_r);
    s_sel_dn = scan_down(sel, cur_r);
    s_lo     = scan_up(up_r, '0);
    s_hi     = scan_down(dn_r, FLR_W'(FLOORS - 1));
    d_hi     = $signed({2'b00, cur_r}) - $signed({2'b00, s_hi.idx});
    d_lo     = $signed({2'b00, s_lo.idx}) - $signed({2'b00, cur_r});
    ch_tv    = 1'b0;
    ch_tf    = '0;
    ch_dir   = dir_r;
    case (mode_r)
      MODE_INITIAL: begin
        ch_tv = 1'b1;
      end
      MODE_UP: begin
        if (dir_r != DIR_NONE) begin
          ch_tv = s_sel_up.found;
          ch_tf = s_sel_up.idx;
        end
      end
      MODE_DOWN: begin
        if (dir_r != DIR_NONE) begin
          ch_tv = s_sel_dn.found;
          ch_tf = s_sel_dn.idx;
        end
      end
      MODE_WAITING: begin
        if (dir_r == DIR_UP) begin
          ch_tv = s_up_cur.found;
          ch_tf = s_up_cur.idx;
        end else if (dir_r == DIR_DOWN) begin
          ch_tv = s_dn_cur.found;
          ch_tf = s_dn_cur.idx;
        end
      end
      MODE_STOPPED: begin
        // nearest-first between lowest up call and highest down call
        if (s_lo.found && s_hi.found) begin
          ch_tv = 1'b1;
          if (d_hi < d_lo) begin
            ch_tf  = s_hi.idx;
            ch_dir = DIR_DOWN;
          end else begin
            ch_tf  = s_lo.idx;
            ch_dir = DIR_UP;
          end
        end else if (s_hi.found) begin
          ch_tv  = 1'b1;
          ch_tf  = s_hi.idx;
          ch_dir = DIR_DOWN;
        end else if (s_lo.found) begin
          ch_tv  = 1'b1;
          ch_tf  = s_lo.idx;
          ch_dir = DIR_UP;
        end
      end
      default: begin
        ch_tv = 1'b0;
      end
    endcase
  end

  // state update for the step the controller asks for
  always_comb begin
    mode_nxt = mode_r;
    cur_nxt  = cur_r;
    tv_nxt   = tv_r;
    tf_nxt   = tf_r;
    dir_nxt  = dir_r;
    up_nxt   = up_r;
    dn_nxt   = dn_r;
    push_n   = 2'd0;
    p0_cmd   = CMD_RESET;
    p0_fl    = '0;
    p1_cmd   = CMD_RESET;

    if (cmd.exec) begin
      case (op_r)
        OP_ADVANCE: begin
          case (mode_r)
            MODE_INITIAL: begin
              up_nxt[0] = 1'b0;
              push_n    = 2'd1;
              p0_cmd    = CMD_RESET;
              mode_nxt  = MODE_STOPPED;
            end
            MODE_STOPPED: begin
              mode_nxt = mode_r;
            end
            MODE_UP, MODE_DOWN: begin
              if (tv_r && (cur_r == tf_r)) begin
                push_n         = 2'd2;
                p0_cmd         = CMD_STOP;
                p1_cmd         = CMD_LIGHT_OFF;
                up_nxt[tf_r]   = 1'b0;
                dn_nxt[tf_r]   = 1'b0;
                mode_nxt       = MODE_WAITING;
              end else if (!tv_r) begin
                mode_nxt = MODE_STOPPED;
              end
            end
            MODE_WAITING: begin
              push_n = 2'd1;
              p0_cmd = CMD_OPEN;
            end
            default: begin
              mode_nxt = MODE_STOPPED;
            end
          endcase
        end
        OP_POSITION: begin
          if (floor_ok(fl_r)) cur_nxt = fl_r;
        end
        OP_CABIN: begin
          if (floor_ok(fl_r) && (fl_r != cur_r)) begin
            if (cur_r < fl_r) up_nxt[fl_r] = 1'b1;
            else dn_nxt[fl_r] = 1'b1;
            push_n = 2'd1;
            p0_cmd = CMD_LIGHT_ON;
            p0_fl  = fl_r;
          end
        end
        OP_HALL: begin
          if (floor_ok(fl_r)) begin
            if (cdir_r == CALL_UP) up_nxt[fl_r] = 1'b1;
            else dn_nxt[fl_r] = 1'b1;
          end
        end
        default: begin
          // door reports and unknown codes change nothing here
          push_n = 2'd0;
        end
      endcase
    end

    if (cmd.pick) begin
      tv_nxt  = ch_tv;
      tf_nxt  = ch_tf;
      dir_nxt = ch_dir;
    end

    // leave towards the target, or settle as stopped
    if (cmd.depart) begin
      if (tv_r && (cur_r < tf_r)) begin
        push_n   = 2'd2;
        p0_cmd   = CMD_CLOSE;
        p1_cmd   = CMD_GO_UP;
        mode_nxt = MODE_UP;
      end else if (tv_r && (cur_r > tf_r)) begin
        push_n   = 2'd2;
        p0_cmd   = CMD_CLOSE;
        p1_cmd   = CMD_GO_DOWN;
        mode_nxt = MODE_DOWN;
      end else begin
        mode_nxt = MODE_STOPPED;
      end
    end
  end

  // light off carries the target floor
  floor_t p1_fl;
  assign p1_fl = (p1_cmd == CMD_LIGHT_OFF) ? tf_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_INITIAL;
      cur_r  <= '0;
      tv_r   <= 1'b0;
      tf_r   <= '0;
      dir_r  <= DIR_NONE;
      up_r   <= '0;
      dn_r   <= '0;
    end else begin
      mode_r <= mode_nxt;
      cur_r  <= cur_nxt;
      tv_r   <= tv_nxt;
      tf_r   <= tf_nxt;
      dir_r  <= dir_nxt;
      up_r   <= up_nxt;
      dn_r   <= dn_nxt;
    end
  end

  // command queue writes, up to two entries a cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      if ((push_n != 2'd0) && (cnt_r == QCNT_W'(i))) begin
        q_cmd_r[i] <= p0_cmd;
        q_fl_r[i]  <= p0_fl;
      end
      if ((push_n == 2'd2) && (QCNT_W'(cnt_r + 1'b1) == QCNT_W'(i))) begin
        q_cmd_r[i] <= p1_cmd;
        q_fl_r[i]  <= p1_fl;
      end
    end
  end

  // queue pointers and output register
  always_comb begin
    cnt_nxt       = QCNT_W'(cnt_r + push_n);
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r;
    out_cmd_nxt   = out_cmd_r;
    out_fl_nxt    = out_fl_r;
    out_last_nxt  = out_last_r;
    if (cmd.latch) begin
      cnt_nxt = '0;
      rd_nxt  = '0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_cmd_nxt   = q_cmd_r[rd_r];
      out_fl_nxt    = q_fl_r[rd_r];
      out_last_nxt  = sts.emit_last;
      rd_nxt        = QCNT_W'(rd_r + 1'b1);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cmd_r  <= out_cmd_nxt;
    out_fl_r   <= out_fl_nxt;
    out_last_r <= out_last_nxt;
  end

  // status to the controller
  always_comb begin
    sts.is_adv    = (op_r == OP_ADVANCE);
    sts.mode      = mode_r;
    sts.cnt_zero  = (cnt_r == '0);
    sts.out_free  = !out_valid_r || out_ready;
    sts.emit_last = (QCNT_W'(rd_r + 1'b1) == cnt_r);
  end

  assign out_valid         = out_valid_r;
  assign out_command       = out_cmd_r;
  assign out_command_floor = out_fl_r;
  assign out_last          = out_last_r;

endmodule

[sv/ers_ctrl.sv]
// ers_ctrl: sequencer that steps the datapath through update, target pick,
// departure and command output; depends on ers_pkg

module ers_ctrl import ers_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (!sts.is_adv) begin
          state_nxt = ST_EMIT;
        end else if (sts.mode == MODE_STOPPED) begin
          state_nxt = ST_DEPART;
        end else if (sts.mode == MODE_WAITING) begin
          state_nxt = ST_PICK_MID;
        end else begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK_MID: begin
        cmd.pick  = 1'b1;
        state_nxt = ST_DEPART;
      end
      ST_DEPART: begin
        cmd.depart = 1'b1;
        state_nxt  = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.cnt_zero) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[test/tb_top.sv]
// tb_top: self-checking bench for elevator_request_scheduler, event items in,
// command items out, each checked against a built-in scheduler predictor.
// Depends on ers_pkg, ers_in_if, ers_out_if and the scheduler RTL.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ers_pkg::*;

  typedef enum int {
    AIM_NONE,
    AIM_STEP,
    AIM_JUMP
  } aim_t;

  // one event item waiting to be driven
  typedef struct {
    logic [OP_W-1:0] op;
    floor_t          flr;
    logic            dir;
    logic            door;
    aim_t            aim;
    bit              pause;
  } event_t;

  // one command item the block should send
  typedef struct {
    cmd_t   cmd;
    floor_t flr;
    logic   last;
  } cmd_item_t;

  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 440;

  logic clk;
  logic rst_n;

  ers_in_if  in_if ();
  ers_out_if out_if ();

  elevator_request_scheduler i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  event_t    pending_events[$];
  cmd_item_t cmd_expect[$];

  // predictor state
  mode_t    car_mode;
  floor_t   car_floor;
  floor_t   goal_floor;
  logic     goal_ok;
  dir_t     car_dir;
  req_vec_t up_calls;
  req_vec_t down_calls;
  logic     door_open;

  int sent_items;
  int checked_cmds;
  int errors;
  int pauses;
  int quiet;

  // clock and reset
  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.operation   = '0;
    in_if.floor       = '0;
    in_if.call_direction = 1'b0;
    in_if.door_is_open = 1'b0;
    out_if.ready      = 1'b0;
  end

  // lowest set bit at or above a floor, -1 if none
  function automatic int first_call_up(req_vec_t mask, int from);
    for (int f = from; f < FLOORS; f++) begin
      if (mask[f]) return f;
    end
    return -1;
  endfunction

  // highest set bit at or below a floor, -1 if none
  function automatic int first_call_down(req_vec_t mask, int from);
    for (int f = from; f >= 0; f--) begin
      if (mask[f]) return f;
    end
    return -1;
  endfunction

  function automatic void push_cmd(cmd_t c, floor_t f);
    cmd_item_t e;
    e.cmd  = c;
    e.flr  = f;
    e.last = 1'b0;
    cmd_expect.push_back(e);
  endfunction

  // next target floor for the current mode
  function automatic void pick_goal();
    int       cur;
    int       t;
    int       lo;
    int       hi;
    req_vec_t sel;
    cur = int'(car_floor);
    t   = -1;
    sel = (car_dir == DIR_UP) ? up_calls : down_calls;
    case (car_mode)
      MODE_INITIAL: t = 0;
      MODE_UP: begin
        if (car_dir != DIR_NONE) t = first_call_up(sel, cur);
      end
      MODE_DOWN: begin
        if (car_dir != DIR_NONE) t = first_call_down(sel, cur);
      end
      MODE_WAITING: begin
        if (car_dir == DIR_UP) t = first_call_up(up_calls, cur);
        else if (car_dir == DIR_DOWN) t = first_call_down(down_calls, cur);
      end
      MODE_STOPPED: begin
        lo = first_call_up(up_calls, 0);
        hi = first_call_down(down_calls, FLOORS - 1);
        if (lo >= 0 && hi >= 0) begin
          // nearer of lowest up call and highest down call, ties go up
          if ((cur - hi) < (lo - cur)) begin
            t       = hi;
            car_dir = DIR_DOWN;
          end else begin
            t       = lo;
            car_dir = DIR_UP;
          end
        end else if (hi >= 0) begin
          t       = hi;
          car_dir = DIR_DOWN;
        end else if (lo >= 0) begin
          t       = lo;
          car_dir = DIR_UP;
        end
      end
      default: ;
    endcase
    if (t < 0 || t >= FLOORS) begin
      goal_ok    = 1'b0;
      goal_floor = '0;
    end else begin
      goal_ok    = 1'b1;
      goal_floor = floor_t'(t);
    end
  endfunction

  // leave towards the target or settle as stopped
  function automatic void depart_or_settle();
    if (goal_ok && car_floor < goal_floor) begin
      push_cmd(CMD_CLOSE, '0);
      push_cmd(CMD_GO_UP, '0);
      car_mode = MODE_UP;
    end else if (goal_ok && car_floor > goal_floor) begin
      push_cmd(CMD_CLOSE, '0);
      push_cmd(CMD_GO_DOWN, '0);
      car_mode = MODE_DOWN;
    end else begin
      car_mode = MODE_STOPPED;
    end
  endfunction

  function automatic void advance_car();
    case (car_mode)
      MODE_INITIAL: begin
        up_calls[0] = 1'b0;
        push_cmd(CMD_RESET, '0);
        car_mode = MODE_STOPPED;
      end
      MODE_STOPPED: depart_or_settle();
      MODE_UP, MODE_DOWN: begin
        if (goal_ok && car_floor == goal_floor) begin
          push_cmd(CMD_STOP, '0);
          push_cmd(CMD_LIGHT_OFF, goal_floor);
          up_calls[goal_floor]   = 1'b0;
          down_calls[goal_floor] = 1'b0;
          car_mode = MODE_WAITING;
        end else if (!goal_ok) begin
          car_mode = MODE_STOPPED;
        end
      end
      MODE_WAITING: begin
        push_cmd(CMD_OPEN, '0);
        pick_goal();
        depart_or_settle();
      end
      default: car_mode = MODE_STOPPED;
    endcase
    pick_goal();
  endfunction

  // expected commands for one accepted event item
  function automatic void predict_commands(logic [OP_W-1:0] op, floor_t f, logic dir,
                                           logic door);
    int n0;
    n0 = cmd_expect.size();
    case (op)
      OP_ADVANCE:  advance_car();
      OP_POSITION: car_floor = f;
      OP_CABIN: begin
        // a cabin call at the current floor is dropped without a light
        if (f != car_floor) begin
          if (car_floor < f) up_calls[f] = 1'b1;
          else down_calls[f] = 1'b1;
          push_cmd(CMD_LIGHT_ON, f);
        end
      end
      OP_HALL: begin
        if (dir == CALL_UP) up_calls[f] = 1'b1;
        else down_calls[f] = 1'b1;
      end
      OP_DOOR: door_open = door;
      default: ;
    endcase
    if (cmd_expect.size() > n0) cmd_expect[cmd_expect.size()-1].last = 1'b1;
  endfunction

  function automatic void add_event(logic [OP_W-1:0] op, int f, logic dir, logic door,
                                    aim_t aim, bit pause);
    event_t e;
    e.op    = op;
    e.flr   = floor_t'(f);
    e.dir   = dir;
    e.door  = door;
    e.aim   = aim;
    e.pause = pause;
    pending_events.push_back(e);
  endfunction

  function automatic logic calm_window();
    return (sent_items >= 180 && sent_items < 300);
  endfunction

  // driver: presents pending event items, predicts on acceptance
  always @(posedge clk) begin
    event_t nxt;
    logic   take;
    logic   go;
    floor_t f;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      quiet       <= 0;
    end else begin
      take = in_if.valid && in_if.ready;
      if (take) begin
        predict_commands(in_if.operation, in_if.floor, in_if.call_direction,
                         in_if.door_is_open);
        sent_items++;
      end
      if (!in_if.valid || take) begin
        go = (pending_events.size() > 0);
        // hold-off until the block has drained
        if (go && pending_events[0].pause &&
            (cmd_expect.size() != 0 || quiet < DRAIN_CYCLES))
          go = 1'b0;
        if (go && !calm_window() && $urandom_range(0, 99) < 15) go = 1'b0;
        if (go) begin
          nxt = pending_events.pop_front();
          f   = nxt.flr;
          // position reports that move the car along its planned trip
          if (nxt.aim == AIM_STEP && goal_ok) begin
            if (car_floor < goal_floor) f = car_floor + 1'b1;
            else if (car_floor > goal_floor) f = car_floor - 1'b1;
            else f = car_floor;
          end else if (nxt.aim == AIM_JUMP && goal_ok) begin
            f = goal_floor;
          end
          if (nxt.pause) pauses++;
          in_if.operation      <= nxt.op;
          in_if.floor          <= f;
          in_if.call_direction <= nxt.dir;
          in_if.door_is_open   <= nxt.door;
          in_if.valid          <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      if (take || cmd_expect.size() != 0) quiet <= 0;
      else if (quiet < 100) quiet <= quiet + 1;
    end
  end

  // monitor: random back-pressure and command item checks
  always @(posedge clk) begin
    cmd_item_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (cmd_expect.size() == 0) begin
          if (errors < 10)
            $display("unexpected command %0d floor %0d last %0b", out_if.command,
                     out_if.command_floor, out_if.last);
          errors++;
        end else begin
          e = cmd_expect.pop_front();
          checked_cmds++;
          if (out_if.command !== e.cmd || out_if.command_floor !== e.flr ||
              out_if.last !== e.last) begin
            if (errors < 10)
              $display("mismatch at command %0d: expected %s floor %0d last %0b, got %0d floor %0d last %0b",
                       checked_cmds, e.cmd.name(), e.flr, e.last, out_if.command,
                       out_if.command_floor, out_if.last);
            errors++;
          end
        end
      end
      out_if.ready <= calm_window() || ($urandom_range(0, 99) >= 15);
    end
  end

  // stimulus and end of run
  initial begin
    int   r;
    int   a;
    aim_t aim;

    car_mode   = MODE_INITIAL;
    car_floor  = '0;
    goal_floor = '0;
    goal_ok    = 1'b0;
    car_dir    = DIR_NONE;
    up_calls   = '0;
    down_calls = '0;
    door_open  = 1'b0;
    sent_items = 0;
    checked_cmds = 0;
    errors     = 0;
    pauses     = 0;

    // directed: reset step, extremes, ignored items and one full trip
    add_event(OP_ADVANCE, 0, 1'b0, 1'b0, AIM_NONE, 1'b0);
    add_event(OP_ADVANCE, 15, 1'b1, 1'b1, AIM_NONE, 1'b0);
    add_event(OP_CABIN, 0, 1'b0, 1'b0, AIM_NONE, 1'b0);
    add_event(OP_CABIN, 15, 1'b1, 1'b0, AIM_NONE, 1'b0);
    add_event(OP_HALL, 0, CALL_UP, 1'b1, AIM_NONE, 1'b0);
    add_event(OP_HALL, 15, 1'b1, 1'b0, AIM_NONE, 1'b0);
    add_event(OP_DOOR, 0, 1'b0, 1'b1, AIM_NONE, 1'b0);
    add_event(OP_DOOR, 15, 1'b1, 1'b0, AIM_NONE, 1'b0);
    add_event(OP_SPARE_5, 3, 1'b0, 1'b0, AIM_NONE, 1'b0);
    add_event(OP_SPARE_6, 15, 1'b1, 1'b1, AIM_NONE, 1'b0);
    add_event(OP_SPARE_7, 0, 1'b0, 1'b1, AIM_NONE, 1'b0);
    add_event(OP_ADVANCE, 0, 1'b0, 1'b0, AIM_NONE, 1'b0);
    add_event(OP_POSITION, 0, 1'b0, 1'b0, AIM_JUMP, 1'b0);
    add_event(OP_ADVANCE, 0, 1'b0, 1'b0, AIM_NONE, 1'b0);
    add_event(OP_ADVANCE, 0, 1'b0, 1'b0, AIM_NONE, 1'b0);
    add_event(OP_POSITION, 0, 1'b0, 1'b0, AIM_JUMP, 1'b0);
    add_event(OP_ADVANCE, 0, 1'b0, 1'b0, AIM_NONE, 1'b0);
    add_event(OP_ADVANCE, 0, 1'b0, 1'b0, AIM_NONE, 1'b0);
    add_event(OP_HALL, 7, 1'b1, 1'b0, AIM_NONE, 1'b1);
    add_event(OP_CABIN, 3, 1'b0, 1'b1, AIM_NONE, 1'b0);
    add_event(OP_ADVANCE, 0, 1'b0, 1'b0, AIM_NONE, 1'b0);
    add_event(OP_POSITION, 0, 1'b0, 1'b0, AIM_STEP, 1'b0);
    add_event(OP_ADVANCE, 0, 1'b0, 1'b0, AIM_NONE, 1'b0);
    add_event(OP_POSITION, 15, 1'b1, 1'b1, AIM_NONE, 1'b0);

    // random: mostly trips driven by calls, steps and arrivals, some noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r   = $urandom_range(0, 99);
      aim = AIM_NONE;
      if (r < 34) begin
        add_event(OP_ADVANCE, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), AIM_NONE, (i == 250));
      end else if (r < 58) begin
        a = $urandom_range(0, 9);
        if (a < 6) aim = AIM_STEP;
        else if (a < 8) aim = AIM_JUMP;
        add_event(OP_POSITION, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), aim, (i == 250));
      end else if (r < 72) begin
        add_event(OP_CABIN, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), AIM_NONE, (i == 250));
      end else if (r < 86) begin
        add_event(OP_HALL, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), AIM_NONE, (i == 250));
      end else if (r < 93) begin
        add_event(OP_DOOR, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), AIM_NONE, (i == 250));
      end else begin
        add_event(OP_W'($urandom_range(5, 7)), $urandom_range(0, 15),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), AIM_NONE,
                  (i == 250));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all items sent, all commands seen, then settle
    while (pending_events.size() != 0 || in_if.valid !== 1'b0) @(posedge clk);
    while (cmd_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d event items with %0d drain pauses; %0d commands checked",
             sent_items, pauses, checked_cmds);
    if (errors == 0) begin
      $display("** elevator_request_scheduler: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** elevator_request_scheduler: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("timeout with %0d commands still expected", cmd_expect.size());
    $display("** elevator_request_scheduler: FAILED **");
    $finish;
  end

endmodule
